@@ sv/capacitive_touch_toggle_detector_defines.svh @@
// Assertion macros used by the touch detector RTL.
`ifndef CAPACITIVE_TOUCH_TOGGLE_DETECTOR_DEFINES_SVH
`define CAPACITIVE_TOUCH_TOGGLE_DETECTOR_DEFINES_SVH

// same-cycle implication, checked outside reset
`define CTT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define CTT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/ctt_pkg.sv @@
// Shared widths, register map and reset values of the touch detector.
package ctt_pkg;

  localparam int unsigned TicksW  = 32;
  localparam int unsigned FreqW   = 35;
  localparam int unsigned ClockW  = 27;
  localparam int unsigned CyclesW = 8;
  localparam int unsigned PctW    = 7;
  localparam int unsigned SumW    = 38;
  localparam int unsigned CalCntW = 4;
  localparam int unsigned ApbDW   = 32;
  localparam int unsigned ApbAW   = 4;

  localparam logic [ClockW-1:0]  ClockReset  = ClockW'(32000000);
  localparam logic [CyclesW-1:0] CyclesReset = CyclesW'(10);
  localparam logic [PctW-1:0]    PctReset    = PctW'(80);

  typedef enum logic [1:0] {
    REG_CLOCK  = 2'd0,
    REG_CYCLES = 2'd1,
    REG_PCT    = 2'd2
  } reg_idx_t;

endpackage

@@ sv/ctt_div.sv @@
// Restoring divider, one quotient bit per cycle.
module ctt_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [ctt_pkg::FreqW-1:0]     dividend,
  input  logic [ctt_pkg::TicksW-1:0]    divisor,
  output logic                          busy,
  output logic                          done,
  output logic [ctt_pkg::FreqW-1:0]     quotient
);

  localparam int unsigned CntW = $clog2(ctt_pkg::FreqW);

  logic [CntW-1:0]               count;
  logic [ctt_pkg::TicksW-1:0]    rem;
  logic [ctt_pkg::TicksW-1:0]    dsr;
  logic [ctt_pkg::FreqW-1:0]     quo;
  logic [ctt_pkg::TicksW:0]      shifted;
  logic [ctt_pkg::TicksW+1:0]    diff;
  logic                          fit;
  logic [ctt_pkg::TicksW-1:0]    rem_next;

  always_comb begin
    shifted  = {rem, quo[ctt_pkg::FreqW-1]};
    diff     = {1'b0, shifted} - {2'b00, dsr};
    fit      = !diff[ctt_pkg::TicksW+1];
    rem_next = fit ? diff[ctt_pkg::TicksW-1:0] : shifted[ctt_pkg::TicksW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= busy && !start && (count == CntW'(ctt_pkg::FreqW - 1));
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
        quo   <= dividend;
        rem   <= '0;
        dsr   <= divisor;
      end else if (busy) begin
        rem   <= rem_next;
        quo   <= {quo[ctt_pkg::FreqW-2:0], fit};
        count <= count + CntW'(1);
        if (count == CntW'(ctt_pkg::FreqW - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

@@ sv/capacitive_touch_toggle_detector.sv @@
// Capacitive touch detector: tick count to frequency, baseline, toggle.
//
// s_axis carries one burst tick count per transfer (tdata[31:0]).
// m_axis returns exactly one result per input transfer: the frequency
// cycles*clock/ticks in Hz (0 for zero ticks), touch flags and LED state.
// The first CAL_COUNT results are baseline samples (tuser high, no touch).
// Configuration goes through the APB port at byte addresses 0, 4 and 8.
// Each item passes from accepted input to m_axis_tvalid through a
// multiply step, the one-bit-per-cycle divider, a product step and a
// decision step. s_axis_tready returns in the same cycle the result is
// loaded, so a new item is accepted only once the last one is through.
// A finished result waits in the output register while the next item is
// taken and divided; if the receiver still stalls when the next result is
// ready, the block holds in its decision step until the register drains.
// Synchronous reset restores the register defaults, clears the baseline,
// the touch history and the LED, and empties the output register.
module capacitive_touch_toggle_detector #(
  parameter int unsigned CAL_COUNT = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [31:0]                   s_axis_tdata,  // [31:0] elapsed_ticks
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [34:0] frequency_hz, [35] touched, [36] toggled, [37] led_on, [39:38] zero
  output logic [39:0]                   m_axis_tdata,
  output logic [0:0]                    m_axis_tuser,  // [0] calibrating
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ctt_pkg::ApbAW-1:0]     paddr,
  input  logic [ctt_pkg::ApbDW-1:0]     pwdata,
  output logic [ctt_pkg::ApbDW-1:0]     prdata,
  output logic                          pready
);

  `include "capacitive_touch_toggle_detector_defines.svh"

  localparam int unsigned MulK = 100 * CAL_COUNT;
  localparam int unsigned KW   = $clog2(MulK + 1);
  localparam int unsigned LhsW = ctt_pkg::FreqW + KW;
  localparam int unsigned RhsW = ctt_pkg::SumW + ctt_pkg::PctW;
  localparam int unsigned CmpW = (LhsW > RhsW) ? LhsW : RhsW;

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_DIV, S_PROD, S_DECIDE} state_t;

  state_t state;

  logic [ctt_pkg::ClockW-1:0]   ref_clock_hz;
  logic [ctt_pkg::CyclesW-1:0]  cycles_per_burst;
  logic [ctt_pkg::PctW-1:0]     threshold_percent;

  logic [ctt_pkg::TicksW-1:0]   ticks;
  logic [ctt_pkg::FreqW-1:0]    freq;
  logic [LhsW-1:0]              lhs;
  logic [RhsW-1:0]              rhs;
  logic [ctt_pkg::CalCntW-1:0]  calib_count;
  logic [ctt_pkg::SumW-1:0]     baseline_sum;
  logic                         last_touched;
  logic                         led_state;

  logic [ctt_pkg::FreqW-1:0]    out_freq;
  logic                         out_cal;
  logic                         out_touched;
  logic                         out_toggled;
  logic                         out_led;

  logic                         div_start;
  logic                         div_busy;
  logic                         div_done;
  logic [ctt_pkg::FreqW-1:0]    div_dividend;
  logic [ctt_pkg::FreqW-1:0]    div_quotient;

  logic                         cfg_write;
  logic                         is_cal;
  logic                         touch;
  logic                         tog;
  logic                         out_free;
  logic [ctt_pkg::SumW:0]       sum_add;
  logic [ctt_pkg::SumW-1:0]     sum_next;

  // configuration registers
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_clock_hz      <= ctt_pkg::ClockReset;
      cycles_per_burst  <= ctt_pkg::CyclesReset;
      threshold_percent <= ctt_pkg::PctReset;
    end else if (cfg_write) begin
      unique case (ctt_pkg::reg_idx_t'(paddr[3:2]))
        ctt_pkg::REG_CLOCK:  ref_clock_hz      <= pwdata[ctt_pkg::ClockW-1:0];
        ctt_pkg::REG_CYCLES: cycles_per_burst  <= pwdata[ctt_pkg::CyclesW-1:0];
        ctt_pkg::REG_PCT:    threshold_percent <= pwdata[ctt_pkg::PctW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ctt_pkg::reg_idx_t'(paddr[3:2]))
      ctt_pkg::REG_CLOCK:  prdata = ctt_pkg::ApbDW'(ref_clock_hz);
      ctt_pkg::REG_CYCLES: prdata = ctt_pkg::ApbDW'(cycles_per_burst);
      ctt_pkg::REG_PCT:    prdata = ctt_pkg::ApbDW'(threshold_percent);
      default:             prdata = '0;
    endcase
  end

  // divider
  assign div_start    = (state == S_MUL);
  assign div_dividend = ctt_pkg::FreqW'(cycles_per_burst) * ctt_pkg::FreqW'(ref_clock_hz);

  ctt_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (ticks),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // decision
  always_comb begin
    is_cal   = calib_count < ctt_pkg::CalCntW'(CAL_COUNT);
    sum_add  = {1'b0, baseline_sum} + (ctt_pkg::SumW + 1)'(freq);
    sum_next = sum_add[ctt_pkg::SumW] ? '1 : sum_add[ctt_pkg::SumW-1:0];
    touch    = !is_cal && (CmpW'(lhs) < CmpW'(rhs));
    tog      = touch && !last_touched;
    out_free = !m_axis_tvalid || m_axis_tready;
  end

  assign s_axis_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      m_axis_tvalid <= 1'b0;
      calib_count   <= '0;
      baseline_sum  <= '0;
      last_touched  <= 1'b0;
      led_state     <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && (state != S_DECIDE)) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            ticks <= s_axis_tdata;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            freq  <= (ticks == '0) ? '0 : div_quotient;
            state <= S_PROD;
          end
        end
        S_PROD: begin
          lhs   <= LhsW'(freq) * LhsW'(KW'(MulK));
          rhs   <= RhsW'(baseline_sum) * RhsW'(threshold_percent);
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          if (out_free) begin
            if (is_cal) begin
              baseline_sum <= sum_next;
              calib_count  <= calib_count + ctt_pkg::CalCntW'(1);
            end else begin
              last_touched <= touch;
            end
            if (tog) begin
              led_state <= !led_state;
            end
            out_freq      <= freq;
            out_cal       <= is_cal;
            out_touched   <= touch;
            out_toggled   <= tog;
            out_led       <= led_state ^ tog;
            m_axis_tvalid <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tdata = {2'b00, out_led, out_toggled, out_touched, out_freq};
  assign m_axis_tuser = out_cal;

  `CTT_ASSERT_IMP(a_ready_div_idle, s_axis_tready, !div_busy && !div_done, "input ready while divider active")
  `CTT_ASSERT_IMP(a_cal_quiet, m_axis_tvalid && out_cal, !out_touched && !out_toggled, "touch reported in calibration")
  `CTT_ASSERT_IMP(a_toggle_needs_touch, m_axis_tvalid && out_toggled, out_touched, "toggle without touch")
  `CTT_ASSERT_NEXT(a_led_follows_toggle, state == S_DECIDE && out_free, out_led == ($past(led_state) ^ out_toggled), "LED state does not follow toggle")

endmodule
